### src/asob_pkg.sv
package asob_pkg;

  localparam int PARTIAL_COUNT = 64;
  localparam int PIDX_W        = 6;    // partial address
  localparam int CNT_W         = 7;    // holds 0 .. PARTIAL_COUNT
  localparam int SINE_STEPS    = 512;
  localparam int ROM_AW        = 9;    // log2(SINE_STEPS)
  localparam int QTR_W         = ROM_AW - 2;
  localparam int QTR_STEPS     = SINE_STEPS / 4;
  localparam int PHASE_W       = ROM_AW + 16;
  localparam int INC_W         = 25;
  localparam int HARM_W        = INC_W + 1;
  localparam int GAIN_W        = 16;
  localparam int MIX_W         = 24;
  localparam int TV_W          = 18;
  localparam int AMP_W         = 16;
  localparam int DET_W         = 17;
  localparam int SMP_W         = 16;
  localparam int TERM_W        = 19;
  localparam int ACC_W         = 26;
  localparam int OUT_W         = 25;
  localparam int IN_TDATA_W    = 96;
  localparam int OUT_TDATA_W   = 32;
  localparam int CFG_DATA_W    = 16;

  localparam logic [HARM_W-1:0] NYQ_LIMIT = HARM_W'(SINE_STEPS) << 15;
  localparam logic [DET_W-1:0]  DET_UNITY = DET_W'(65536);
  localparam logic [CNT_W-1:0]  PARTIALS_RESET = CNT_W'(PARTIAL_COUNT);
  localparam logic [CFG_DATA_W-1:0] VOLUME_RESET = CFG_DATA_W'(32768);

  localparam logic CFG_PARTIALS = 1'b0;
  localparam logic CFG_VOLUME   = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_AMP  = 2'd1,
    REQ_DET  = 2'd2,
    REQ_CLR  = 2'd3
  } req_t;

  // Issue of one partial into the voice pipeline.
  typedef struct packed {
    logic              valid;
    logic [PIDX_W-1:0] idx;
    logic [INC_W-1:0]  harm;
  } issue_t;

  typedef struct packed {
    logic              amp_we;
    logic              det_we;
    logic [PIDX_W-1:0] addr;
    logic [AMP_W-1:0]  amp;
    logic [DET_W-1:0]  det;
  } coef_wr_t;

  typedef struct packed {
    logic               we;
    logic [PIDX_W-1:0]  addr;
    logic [PHASE_W-1:0] data;
  } ph_wb_t;

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic signed [AMP_W-1:0] amp;
    logic [DET_W-1:0]       det;
  } part_rd_t;

  // Quarter-wave sine table, entries 0 .. QTR_STEPS, built at elaboration
  // from a fixed-point Taylor series of sin(x) in Q30.
  localparam int QTAB_LAST = QTR_STEPS;
  typedef logic [14:0] qtab_t [0:QTAB_LAST];

  // The series divisors (2n)(2n+1) are applied as reciprocals rounded up.
  // Every numerator in the series stays below 2^32, so the product shifted
  // down by SERIES_SHIFT is exactly the floor of the quotient.
  localparam int SERIES_SHIFT = 40;
  localparam longint unsigned RECIP_6   = ((64'd1 << SERIES_SHIFT) + 64'd5) / 64'd6;
  localparam longint unsigned RECIP_20  = ((64'd1 << SERIES_SHIFT) + 64'd19) / 64'd20;
  localparam longint unsigned RECIP_42  = ((64'd1 << SERIES_SHIFT) + 64'd41) / 64'd42;
  localparam longint unsigned RECIP_72  = ((64'd1 << SERIES_SHIFT) + 64'd71) / 64'd72;
  localparam longint unsigned RECIP_110 = ((64'd1 << SERIES_SHIFT) + 64'd109) / 64'd110;
  localparam longint unsigned RECIP_156 = ((64'd1 << SERIES_SHIFT) + 64'd155) / 64'd156;

  function automatic longint unsigned series_recip(input int n);
    case (n)
      1:       series_recip = RECIP_6;
      2:       series_recip = RECIP_20;
      3:       series_recip = RECIP_42;
      4:       series_recip = RECIP_72;
      5:       series_recip = RECIP_110;
      default: series_recip = RECIP_156;
    endcase
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t           tab;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    logic [127:0]    wide;
    longint          sum;
    longint          r;
    int              m;
    int              n;
    for (m = 0; m <= QTAB_LAST; m++) begin
      u = longint'(m) << (30 - QTR_W);
      x = (u * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        wide = 128'(term) * 128'(series_recip(n));
        term = wide[SERIES_SHIFT +: 64];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum * 32767 + (longint'(1) << 29)) >>> 30;
      if (r > 32767) begin
        r = 32767;
      end
      tab[m] = 15'(r);
    end
    return tab;
  endfunction

  localparam qtab_t SINE_QTAB = build_qtab();

  // Full-cycle sine from the quarter table by symmetry.
  function automatic logic signed [SMP_W-1:0] sine_at(input logic [ROM_AW-1:0] k);
    logic [QTR_W:0] m;
    logic [14:0]    mag;
    m = {1'b0, k[QTR_W-1:0]};
    if (k[QTR_W]) begin
      m = (QTR_W+1)'(QTR_STEPS) - m;
    end
    mag = SINE_QTAB[m];
    if (k[ROM_AW-1]) begin
      sine_at = -$signed({1'b0, mag});
    end else begin
      sine_at = $signed({1'b0, mag});
    end
  endfunction

endpackage

### src/asob_store.sv
module asob_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [asob_pkg::PIDX_W-1:0] rd_addr,
  input  asob_pkg::coef_wr_t        coef_wr,
  input  logic                      clr_phase,
  input  asob_pkg::ph_wb_t          ph_wb,
  output asob_pkg::part_rd_t        rd_data
);

  typedef struct packed {
    logic [asob_pkg::AMP_W-1:0] amp;
    logic [asob_pkg::DET_W-1:0] det;
  } coef_t;

  logic [asob_pkg::PHASE_W-1:0]       ph_mem [asob_pkg::PARTIAL_COUNT];
  coef_t                              coef_mem [asob_pkg::PARTIAL_COUNT];
  logic [asob_pkg::PARTIAL_COUNT-1:0] ph_vld_r;
  logic [asob_pkg::PARTIAL_COUNT-1:0] amp_vld_r;
  logic [asob_pkg::PARTIAL_COUNT-1:0] det_vld_r;

  logic [asob_pkg::PHASE_W-1:0] ph_q_r;
  coef_t                        coef_q_r;
  logic                         ph_vld_q_r;
  logic                         amp_vld_q_r;
  logic                         det_vld_q_r;

  // Entries never written since reset (phase entries also since a phase clear)
  // read as their reset value through these valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_vld_r  <= '0;
      amp_vld_r <= '0;
      det_vld_r <= '0;
    end else begin
      if (clr_phase) begin
        ph_vld_r <= '0;
      end else if (ph_wb.we) begin
        ph_vld_r[ph_wb.addr] <= 1'b1;
      end
      if (coef_wr.amp_we) begin
        amp_vld_r[coef_wr.addr] <= 1'b1;
      end
      if (coef_wr.det_we) begin
        det_vld_r[coef_wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ph_wb.we) begin
      ph_mem[ph_wb.addr] <= ph_wb.data;
    end
    if (coef_wr.amp_we) begin
      coef_mem[coef_wr.addr].amp <= coef_wr.amp;
    end
    if (coef_wr.det_we) begin
      coef_mem[coef_wr.addr].det <= coef_wr.det;
    end
    if (rd_en) begin
      ph_q_r      <= ph_mem[rd_addr];
      coef_q_r    <= coef_mem[rd_addr];
      ph_vld_q_r  <= ph_vld_r[rd_addr];
      amp_vld_q_r <= amp_vld_r[rd_addr];
      det_vld_q_r <= det_vld_r[rd_addr];
    end
  end

  always_comb begin
    rd_data.phase = ph_vld_q_r ? ph_q_r : '0;
    rd_data.amp   = amp_vld_q_r ? $signed(coef_q_r.amp) : '0;
    rd_data.det   = det_vld_q_r ? coef_q_r.det : asob_pkg::DET_UNITY;
  end

endmodule

### src/asob_voice.sv
module asob_voice (
  input  logic                              clk,
  input  logic                              rst_n,
  input  asob_pkg::issue_t                  iss,
  input  logic                              start,
  input  logic [2*asob_pkg::GAIN_W-1:0]     gain,
  input  asob_pkg::part_rd_t                rd_data,
  output asob_pkg::ph_wb_t                  ph_wb,
  output logic                              busy,
  output logic signed [asob_pkg::ACC_W-1:0] acc
);

  localparam int STAGES = 8;

  logic [STAGES-1:0] vld_r;

  // Stage 1: memory data arrives; phase step multiply.
  logic [asob_pkg::PIDX_W-1:0] s1_idx_r;
  logic [asob_pkg::INC_W-1:0]  s1_harm_r;
  logic [asob_pkg::INC_W+asob_pkg::DET_W-1:0] step_prod;

  // Stage 2: phase update and write back.
  logic [asob_pkg::PIDX_W-1:0]   s2_idx_r;
  logic [asob_pkg::PHASE_W-1:0]  s2_ph_r;
  logic [asob_pkg::PHASE_W-1:0]  s2_step_r;
  logic signed [asob_pkg::AMP_W-1:0] s2_amp_r;
  logic [asob_pkg::PHASE_W-1:0]  ph_new;

  // Stage 3: table lookups.
  logic [asob_pkg::PHASE_W-1:0]  s3_ph_r;
  logic signed [asob_pkg::AMP_W-1:0] s3_amp_r;

  // Stage 4: interpolation.
  logic signed [asob_pkg::SMP_W-1:0] s4_ra_r;
  logic signed [asob_pkg::SMP_W-1:0] s4_rb_r;
  logic [15:0]                       s4_f_r;
  logic signed [asob_pkg::AMP_W-1:0] s4_amp_r;
  logic signed [asob_pkg::SMP_W:0]   interp_diff;
  logic signed [2*asob_pkg::SMP_W+1:0] interp_prod;
  logic signed [asob_pkg::SMP_W+1:0] interp_sum;

  // Stage 5: sample times amplitude.
  logic signed [asob_pkg::SMP_W-1:0] s5_s_r;
  logic signed [asob_pkg::AMP_W-1:0] s5_amp_r;

  // Stage 6: times envelope*volume, split in two halves.
  logic signed [31:0] s6_p1_r;

  // Stage 7: recombine and scale.
  logic signed [48:0] s7_a_r;
  logic signed [48:0] s7_b_r;
  logic signed [48:0] b_shift;
  logic signed [49:0] t_sum;

  // Stage 8: accumulate.
  logic signed [asob_pkg::TERM_W-1:0] s8_term_r;
  logic signed [asob_pkg::ACC_W-1:0]  acc_r;

  assign step_prod   = s1_harm_r * rd_data.det;
  assign ph_new      = s2_ph_r + s2_step_r;
  assign interp_diff = $signed({s4_rb_r[asob_pkg::SMP_W-1], s4_rb_r})
                     - $signed({s4_ra_r[asob_pkg::SMP_W-1], s4_ra_r});
  assign interp_prod = interp_diff * $signed({1'b0, s4_f_r});
  assign interp_sum  = $signed({{2{s4_ra_r[asob_pkg::SMP_W-1]}}, s4_ra_r})
                     + $signed(interp_prod[2*asob_pkg::SMP_W+1:16]);
  assign b_shift     = s7_b_r >>> 16;
  assign t_sum       = $signed({s7_a_r[48], s7_a_r}) + $signed({b_shift[48], b_shift});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], iss.valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= iss.idx;
    s1_harm_r <= iss.harm;

    s2_idx_r  <= s1_idx_r;
    s2_ph_r   <= rd_data.phase;
    // Only the low phase bits survive the wrap modulo the table length.
    s2_step_r <= step_prod[asob_pkg::PHASE_W+15:16];
    s2_amp_r  <= rd_data.amp;

    s3_ph_r   <= ph_new;
    s3_amp_r  <= s2_amp_r;

    s4_ra_r   <= asob_pkg::sine_at(s3_ph_r[asob_pkg::PHASE_W-1:16]);
    s4_rb_r   <= asob_pkg::sine_at(s3_ph_r[asob_pkg::PHASE_W-1:16] + 1'b1);
    s4_f_r    <= s3_ph_r[15:0];
    s4_amp_r  <= s3_amp_r;

    s5_s_r    <= interp_sum[asob_pkg::SMP_W-1:0];
    s5_amp_r  <= s4_amp_r;

    s6_p1_r   <= s5_s_r * s5_amp_r;

    s7_a_r    <= s6_p1_r * $signed({1'b0, gain[2*asob_pkg::GAIN_W-1:asob_pkg::GAIN_W]});
    s7_b_r    <= s6_p1_r * $signed({1'b0, gain[asob_pkg::GAIN_W-1:0]});

    // The full product is a*2^16 + b; floor by 2^45 equals floor of
    // (a + floor(b / 2^16)) by 2^29.
    s8_term_r <= t_sum[29+asob_pkg::TERM_W-1:29];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (start) begin
      acc_r <= '0;
    end else if (vld_r[STAGES-1]) begin
      acc_r <= acc_r
             + $signed({{(asob_pkg::ACC_W-asob_pkg::TERM_W){s8_term_r[asob_pkg::TERM_W-1]}},
                        s8_term_r});
    end
  end

  always_comb begin
    ph_wb.we   = vld_r[1];
    ph_wb.addr = s2_idx_r;
    ph_wb.data = ph_new;
  end

  assign busy = |vld_r;
  assign acc  = acc_r;

endmodule

### src/additive_sine_oscillator_bank.sv
// Bank of up to 64 harmonic sine oscillators summed into an audio sample.
// Input stream: in_tuser selects the transaction kind (sample tick, write
// amplitude, write detune, clear all phases); in_tdata carries the fields.
// A tick returns one result on the output stream: the input sample plus the
// sum of all sounding partials, saturated, and the number of partials summed.
// Table writes and phase clears return nothing.
// Configuration writes (partial count, master volume) go through the cfg_
// channel, which is always ready; write them only while the bank is idle.
// Partial state sits in synchronous memories with one read and one
// write port, and one read-modify-write pipeline walks the partials at one
// per cycle. After the last sounding partial is issued, the bank waits for
// the pipeline to drain, loads the result once the output register is free
// and returns to idle; no new item is accepted while a tick is in progress.
// A finished result sits in an output register; while the receiver stalls,
// the next item is still accepted and worked on, and only the loading of a
// second result waits for the first to be taken.
// Reset restores 64 partials and unity volume, zero phases and amplitudes,
// unity detune; no clearing pass is needed after reset.
module additive_sine_oscillator_bank (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // base_increment[24:0], envelope_gain[40:25], mix_in[64:41],
  // partial_index[70:65], table_value[88:71], zero[95:89]
  input  logic [asob_pkg::IN_TDATA_W-1:0]      in_tdata,
  // req_type[1:0]
  input  logic [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // mixed_sample[24:0], partials_sounded[31:25]
  output logic [asob_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [asob_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r;

  logic [asob_pkg::INC_W-1:0]        in_inc;
  logic [asob_pkg::GAIN_W-1:0]       in_env;
  logic signed [asob_pkg::MIX_W-1:0] in_mix;
  logic [asob_pkg::PIDX_W-1:0]       in_idx;
  logic signed [asob_pkg::TV_W-1:0]  in_tv;
  asob_pkg::req_t                    in_req;
  logic                              in_acc;
  logic                              tick_acc;

  logic [asob_pkg::CNT_W-1:0]        piu_r;
  logic [asob_pkg::GAIN_W-1:0]       vol_r;
  logic [asob_pkg::INC_W-1:0]        inc_r;
  logic signed [asob_pkg::MIX_W-1:0] mix_r;
  logic [2*asob_pkg::GAIN_W-1:0]     gain_r;
  logic [asob_pkg::CNT_W-1:0]        limit_r;
  logic [asob_pkg::CNT_W-1:0]        j_r;
  logic [asob_pkg::HARM_W-1:0]       harm_r;
  logic                              out_valid_r;
  logic [asob_pkg::OUT_W-1:0]        out_sample_r;
  logic [asob_pkg::CNT_W-1:0]        out_cnt_r;

  logic                              go;
  logic                              load_out;
  logic                              busy;
  logic signed [asob_pkg::ACC_W-1:0] acc;
  logic signed [asob_pkg::ACC_W:0]   total;
  logic [asob_pkg::OUT_W-1:0]        sat_sample;
  logic [asob_pkg::AMP_W-1:0]        amp_sat;
  logic [asob_pkg::CNT_W-1:0]        limit_nxt;

  asob_pkg::issue_t   iss;
  asob_pkg::coef_wr_t coef_wr;
  asob_pkg::ph_wb_t   ph_wb;
  asob_pkg::part_rd_t rd_data;

  assign in_inc = in_tdata[24:0];
  assign in_env = in_tdata[40:25];
  assign in_mix = $signed(in_tdata[64:41]);
  assign in_idx = in_tdata[70:65];
  assign in_tv  = $signed(in_tdata[88:71]);
  assign in_req = asob_pkg::req_t'(in_tuser);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && (in_req == asob_pkg::REQ_TICK);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= asob_pkg::PARTIALS_RESET;
      vol_r <= asob_pkg::VOLUME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        asob_pkg::CFG_PARTIALS: piu_r <= cfg_data[asob_pkg::CNT_W-1:0];
        asob_pkg::CFG_VOLUME:   vol_r <= cfg_data;
        default:                ;
      endcase
    end
  end

  // Amplitude writes saturate to Q1.15; detune takes the low 17 bits.
  always_comb begin
    if (in_tv > $signed(asob_pkg::TV_W'(32767))) begin
      amp_sat = 16'h7FFF;
    end else if (in_tv < $signed(-asob_pkg::TV_W'(32768))) begin
      amp_sat = 16'h8000;
    end else begin
      amp_sat = in_tv[asob_pkg::AMP_W-1:0];
    end
  end

  // Partial indices are 6 bits wide, so every write lands in the bank.
  always_comb begin
    coef_wr.amp_we = in_acc && (in_req == asob_pkg::REQ_AMP);
    coef_wr.det_we = in_acc && (in_req == asob_pkg::REQ_DET);
    coef_wr.addr   = in_idx;
    coef_wr.amp    = amp_sat;
    coef_wr.det    = in_tv[asob_pkg::DET_W-1:0];
  end

  assign limit_nxt = (piu_r > asob_pkg::PARTIALS_RESET) ? asob_pkg::PARTIALS_RESET : piu_r;

  // Partials sound from the lowest upward and stop at the first one past
  // the count or above Nyquist.
  assign go = (state_r == S_RUN) && (j_r < limit_r) && (harm_r <= asob_pkg::NYQ_LIMIT);

  // The output register takes a new result when it is empty or being drained.
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    iss.valid = go;
    iss.idx   = j_r[asob_pkg::PIDX_W-1:0];
    iss.harm  = harm_r[asob_pkg::INC_W-1:0];
  end

  asob_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (go),
    .rd_addr   (j_r[asob_pkg::PIDX_W-1:0]),
    .coef_wr   (coef_wr),
    .clr_phase (in_acc && (in_req == asob_pkg::REQ_CLR)),
    .ph_wb     (ph_wb),
    .rd_data   (rd_data)
  );

  asob_voice u_voice (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (iss),
    .start   (tick_acc),
    .gain    (gain_r),
    .rd_data (rd_data),
    .ph_wb   (ph_wb),
    .busy    (busy),
    .acc     (acc)
  );

  assign total = $signed({acc[asob_pkg::ACC_W-1], acc})
               + $signed({{(asob_pkg::ACC_W+1-asob_pkg::MIX_W){mix_r[asob_pkg::MIX_W-1]}},
                          mix_r});

  always_comb begin
    if (total > $signed((asob_pkg::ACC_W+1)'(16777215))) begin
      sat_sample = 25'h0FF_FFFF;
    end else if (total < $signed(-(asob_pkg::ACC_W+1)'(16777216))) begin
      sat_sample = 25'h100_0000;
    end else begin
      sat_sample = total[asob_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (tick_acc) begin
            inc_r   <= in_inc;
            mix_r   <= in_mix;
            gain_r  <= in_env * vol_r;
            limit_r <= limit_nxt;
            j_r     <= '0;
            harm_r  <= {1'b0, in_inc};
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (go) begin
            j_r    <= j_r + 1'b1;
            harm_r <= harm_r + {1'b0, inc_r};
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!busy) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            out_sample_r <= sat_sample;
            out_cnt_r    <= j_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_sample_r};

  a_issue_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> (j_r < asob_pkg::PARTIALS_RESET + 1'b1) && (j_r < limit_r))
    else $error("partial issued beyond the count limit");

  a_fin_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !busy)
    else $error("result taken while partials are still in flight");

  a_write_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    ph_wb.we |-> (state_r == S_RUN) || (state_r == S_DRAIN))
    else $error("phase written back outside a tick");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r <= asob_pkg::PARTIALS_RESET))
    else $error("partial count above bank size");

endmodule

### tb/sv/asob_mix_checker.sv
module asob_mix_checker
  import asob_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample;
    logic [CNT_W-1:0]        sounded;
  } mix_result_t;

  logic signed [15:0]      sine_tab [0:SINE_STEPS];
  logic [PHASE_W-1:0]      phase_acc [PARTIAL_COUNT];
  logic signed [AMP_W-1:0] amp_tab [PARTIAL_COUNT];
  logic [DET_W-1:0]        det_tab [PARTIAL_COUNT];
  logic [CNT_W-1:0]        live_partials;
  logic [GAIN_W-1:0]       volume;
  mix_result_t             expected_mix [$];

  // One full-cycle sine point: quarter-wave Taylor series in Q30, then scaled
  // to Q1.15 with rounding and mirrored into the other quadrants.
  function automatic logic signed [15:0] sine_point(input int k);
    u64_t   t;
    u64_t   u;
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint sum;
    longint r;
    int     quad;
    int     n;
    t = ((u64_t'(k) << 32) / u64_t'(SINE_STEPS)) & 64'hFFFF_FFFF;
    quad = int'(t >> 30) & 3;
    u = t & ((u64_t'(1) << 30) - 1);
    if (quad & 1) begin
      u = (u64_t'(1) << 30) - u;
    end
    x = (u * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      term = term / u64_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = longint'((u64_t'(sum) * 32767 + (u64_t'(1) << 29)) >> 30);
    if (r > 32767) begin
      r = 32767;
    end
    return 16'((quad & 2) ? -r : r);
  endfunction

  // Advances every sounding partial and returns the mixed sample of one tick.
  function automatic mix_result_t sound_tick(input logic [INC_W-1:0] inc,
                                             input logic [GAIN_W-1:0] env,
                                             input logic signed [MIX_W-1:0] mix);
    longint             harm;
    longint             acc;
    longint             s;
    longint             fr;
    int                 lim;
    int                 j;
    int                 ip;
    int                 cnt;
    logic [PHASE_W-1:0] ph;
    mix_result_t        res;
    lim = (int'(live_partials) > PARTIAL_COUNT) ? PARTIAL_COUNT : int'(live_partials);
    acc = 0;
    cnt = 0;
    for (j = 0; j < lim; j++) begin
      harm = longint'(inc) * (j + 1);
      // Partials stop at the first harmonic above Nyquist.
      if (harm > (longint'(SINE_STEPS) << 15)) begin
        break;
      end
      ph = PHASE_W'(longint'(phase_acc[j]) + ((harm * longint'(det_tab[j])) >>> 16));
      phase_acc[j] = ph;
      ip = int'(ph >> 16);
      fr = longint'(ph[15:0]);
      s = (65536 - fr) * longint'(sine_tab[ip]) + fr * longint'(sine_tab[ip + 1]);
      s = s >>> 16;
      acc += (s * longint'(env) * longint'(amp_tab[j]) * longint'(volume)) >>> 45;
      cnt++;
    end
    acc += longint'(mix);
    if (acc > 16777215) begin
      acc = 16777215;
    end else if (acc < -16777216) begin
      acc = -16777216;
    end
    res.sample = OUT_W'(acc);
    res.sounded = CNT_W'(cnt);
    return res;
  endfunction

  initial begin
    for (int k = 0; k <= SINE_STEPS; k++) begin
      sine_tab[k] = sine_point(k);
    end
  end

  always @(posedge clk) begin
    mix_result_t             got;
    mix_result_t             want;
    logic signed [TV_W-1:0]  tv;
    logic [PIDX_W-1:0]       pidx;
    if (!rst_n) begin
      for (int j = 0; j < PARTIAL_COUNT; j++) begin
        phase_acc[j] = '0;
        amp_tab[j] = '0;
        det_tab[j] = DET_UNITY;
      end
      live_partials = PARTIALS_RESET;
      volume = VOLUME_RESET;
      expected_mix.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sample = out_tdata[OUT_W-1:0];
        got.sounded = out_tdata[OUT_W +: CNT_W];
        if (expected_mix.size() == 0) begin
          if (fail_count < 10) begin
            $display("mismatch: unexpected result sample %0d partials %0d",
                     got.sample, got.sounded);
          end
          fail_count++;
        end else begin
          want = expected_mix.pop_front();
          checked++;
          if (got.sample !== want.sample || got.sounded !== want.sounded) begin
            if (fail_count < 10) begin
              $display("mismatch: sample exp %0d got %0d, partials exp %0d got %0d",
                       want.sample, got.sample, want.sounded, got.sounded);
            end
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PARTIALS: live_partials = cfg_data[CNT_W-1:0];
          CFG_VOLUME:   volume = cfg_data;
        endcase
      end

      if (in_tvalid && in_tready) begin
        // Field layout: base_increment, envelope_gain, mix_in, partial_index,
        // table_value from the low bit up.
        pidx = in_tdata[70:65];
        tv = in_tdata[88:71];
        case (req_t'(in_tuser))
          REQ_TICK: begin
            expected_mix.push_back(sound_tick(in_tdata[24:0], in_tdata[40:25],
                                              in_tdata[64:41]));
          end
          REQ_AMP: begin
            if (tv > 18'sd32767) begin
              amp_tab[pidx] = 16'sd32767;
            end else if (tv < -18'sd32768) begin
              amp_tab[pidx] = -16'sd32768;
            end else begin
              amp_tab[pidx] = AMP_W'(tv);
            end
          end
          REQ_DET: det_tab[pidx] = tv[DET_W-1:0];
          REQ_CLR: begin
            for (int j = 0; j < PARTIAL_COUNT; j++) begin
              phase_acc[j] = '0;
            end
          end
        endcase
      end
      pending = expected_mix.size();
    end
  end

endmodule

### tb/sv/additive_sine_oscillator_bank_test.sv
module additive_sine_oscillator_bank_test;
  import asob_pkg::*;

  localparam int BANK_LATENCY = 90;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int settings_used = 1;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  always #5 clk = ~clk;

  additive_sine_oscillator_bank DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  asob_mix_checker mix_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  task automatic send_item(input req_t kind, input logic [INC_W-1:0] inc,
                           input logic [GAIN_W-1:0] env, input logic [MIX_W-1:0] mix,
                           input logic [PIDX_W-1:0] pidx, input logic [TV_W-1:0] tv);
    int gap;
    if (in_calm) begin
      in_calm = ($urandom_range(0, 9) != 0);
    end else begin
      in_calm = ($urandom_range(0, 40) == 0);
    end
    gap = in_calm ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, tv, pidx, mix, env, inc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_tick(input logic [INC_W-1:0] inc, input logic [GAIN_W-1:0] env,
                           input logic [MIX_W-1:0] mix);
    send_item(REQ_TICK, inc, env, mix, PIDX_W'($urandom), TV_W'($urandom));
  endtask

  task automatic send_write(input req_t kind, input logic [PIDX_W-1:0] pidx,
                            input logic [TV_W-1:0] tv);
    send_item(kind, INC_W'($urandom), GAIN_W'($urandom), MIX_W'($urandom), pidx, tv);
  endtask

  task automatic send_clear();
    send_item(REQ_CLR, INC_W'($urandom), GAIN_W'($urandom), MIX_W'($urandom),
              PIDX_W'($urandom), TV_W'($urandom));
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every outstanding tick result, then lets a table write or
  // phase clear still in the pipeline finish.
  task automatic drain();
    int waited;
    @(negedge clk);
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (BANK_LATENCY) @(negedge clk);
  endtask

  // Every partial gets nearly the same phase step, so after 32 ticks all of them
  // sit near the sine peak and the sum swings toward its largest magnitude.
  task automatic build_chord(input bit falling);
    send_clear();
    for (int j = 0; j < PARTIAL_COUNT; j++) begin
      send_write(REQ_AMP, PIDX_W'(j), falling ? 18'h38000 : 18'h07FFF);
    end
    for (int j = 0; j < PARTIAL_COUNT; j++) begin
      send_write(REQ_DET, PIDX_W'(j), TV_W'(65536 / (j + 1)));
    end
    for (int t = 0; t < 36; t++) begin
      send_tick(INC_W'(1 << 18), (t % 5 == 4) ? GAIN_W'($urandom) : 16'hFFFF,
                (t % 4 == 3) ? MIX_W'($urandom) : (falling ? 24'h800000 : 24'h7FFFFF));
    end
  endtask

  task automatic random_item();
    int                pick;
    int                cls;
    logic [INC_W-1:0]  inc;
    logic [GAIN_W-1:0] env;
    logic [TV_W-1:0]   tv;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      cls = $urandom_range(0, 9);
      case (cls)
        0:       inc = '0;
        1, 2, 3, 4: inc = INC_W'($urandom_range(0, 1 << 18));
        5, 6:    inc = INC_W'($urandom_range(0, 1 << 21));
        7:       inc = INC_W'((1 << 24) / $urandom_range(1, 64) + $urandom_range(0, 1));
        8:       inc = INC_W'($urandom);
        default: inc = INC_W'($urandom_range(1 << 24, (1 << 25) - 1));
      endcase
      cls = $urandom_range(0, 7);
      env = (cls == 0) ? 16'd0 : (cls == 1) ? 16'hFFFF : GAIN_W'($urandom);
      send_tick(inc, env, MIX_W'($urandom));
    end else if (pick < 80) begin
      if ($urandom_range(0, 4) == 0) begin
        tv = TV_W'($urandom);
      end else begin
        tv = TV_W'(int'($urandom_range(0, 65535)) - 32768);
      end
      send_write(REQ_AMP, PIDX_W'($urandom), tv);
    end else if (pick < 96) begin
      if ($urandom_range(0, 4) == 0) begin
        tv = TV_W'($urandom);
      end else begin
        tv = TV_W'(65536 + int'($urandom_range(0, 8192)) - 4096);
      end
      send_write(REQ_DET, PIDX_W'($urandom), tv);
    end else begin
      send_clear();
    end
  endtask

  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (out_calm) begin
        out_calm = ($urandom_range(0, 9) != 0);
      end else begin
        out_calm = ($urandom_range(0, 40) == 0);
      end
      stall = out_calm ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int          parts;
    int          phase_len;
    logic [15:0] vol;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    send_tick('0, 16'd32768, 24'h800000);
    send_tick('0, 16'd0, 24'h7FFFFF);
    send_write(REQ_AMP, 6'd0, 18'h1FFFF);
    send_write(REQ_AMP, 6'd1, 18'h30000);
    send_write(REQ_AMP, 6'd63, 18'h07FFF);
    send_write(REQ_AMP, 6'd2, 18'h38000);
    send_write(REQ_AMP, 6'd3, 18'h3FFFF);
    send_write(REQ_DET, 6'd1, 18'h1FFFF);
    send_write(REQ_DET, 6'd2, 18'h30000);
    send_write(REQ_DET, 6'd3, 18'h3FFFF);
    send_write(REQ_DET, 6'd63, 18'h00000);
    send_tick(25'd16777216, 16'hFFFF, 24'h7FFFFF);
    send_tick(25'd16777217, 16'hFFFF, 24'h800000);
    send_tick(25'h1FFFFFF, 16'hFFFF, 24'hFFFFFF);
    send_tick(25'd262144, 16'd32768, 24'd0);
    send_tick(25'd262145, 16'hFFFF, 24'd0);
    send_tick('0, 16'hFFFF, 24'h123456);
    send_tick(25'd8388608, 16'hFFFF, 24'd0);
    send_clear();
    send_tick(25'd12345, 16'hFFFF, 24'd0);
    send_tick(25'd4194304, 16'h8000, 24'd1);
    send_write(REQ_AMP, 6'd4, 18'h04000);
    send_tick(25'd100000, 16'hFFFF, 24'h800000);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin parts = 64; vol = 16'hFFFF; end
        1: begin parts = 0; vol = 16'd32768; end
        2: begin parts = 127; vol = 16'd0; end
        3: begin parts = 1; vol = 16'hFFFF; end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            parts = $urandom_range(65, 127);
          end else begin
            parts = $urandom_range(1, 64);
          end
          vol = 16'($urandom);
        end
      endcase
      drain();
      write_reg(CFG_PARTIALS, CFG_DATA_W'(parts));
      write_reg(CFG_VOLUME, vol);
      settings_used++;
      if (ph == 0) begin
        build_chord(1'b0);
        build_chord(1'b1);
      end else begin
        phase_len = (ph == 1) ? 60 : 190;
        for (int n = 0; n < phase_len; n++) begin
          random_item();
        end
      end
    end

    drain();
    $display("summary: %0d transactions sent under %0d register settings", items_sent,
             settings_used);
    $display("summary: %0d tick results checked, %0d still outstanding", checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
